### rtl/isd_pkg.sv
// ----------------------------------------------------------------------------
// isd_pkg: shared definitions of the imu stillness detector
// widths, register map, reset values and the divider interface types
// ----------------------------------------------------------------------------
package isd_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int COUNT_BITS   = 16;
  localparam int SUM_BITS     = SAMPLE_BITS + COUNT_BITS;
  localparam int REG_BITS     = 16;
  localparam int REG_IDX_BITS = 2;
  localparam int NUM_AXES     = 6;
  localparam int ACC_AXES     = 3;
  localparam int AXIS_BITS    = $clog2(NUM_AXES);
  localparam int DIV_CNT_BITS = $clog2(SUM_BITS);

  // register map
  localparam logic [REG_IDX_BITS-1:0] REG_GYRO_THR  = REG_IDX_BITS'(0);
  localparam logic [REG_IDX_BITS-1:0] REG_ACCEL_THR = REG_IDX_BITS'(1);
  localparam logic [REG_IDX_BITS-1:0] REG_MIN_SAMP  = REG_IDX_BITS'(2);

  localparam logic [REG_BITS-1:0] GYRO_THR_RST  = REG_BITS'(64);
  localparam logic [REG_BITS-1:0] ACCEL_THR_RST = REG_BITS'(128);
  localparam logic [REG_BITS-1:0] MIN_SAMP_RST  = REG_BITS'(200);

  typedef struct packed {
    logic                  start;
    logic [SUM_BITS-1:0]   dividend;  // two's complement
    logic [COUNT_BITS-1:0] divisor;   // unsigned, nonzero
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic [SAMPLE_BITS-1:0] quotient; // truncated toward zero
  } div_rsp_t;

endpackage

### rtl/isd_serial_div.sv
// ----------------------------------------------------------------------------
// isd_serial_div: bit-serial signed divider
// restoring division of a window sum by the count, one quotient bit per cycle
// ----------------------------------------------------------------------------
module isd_serial_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  isd_pkg::div_req_t req_i,
  output isd_pkg::div_rsp_t rsp_o
);
  import isd_pkg::*;

  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic [DIV_CNT_BITS-1:0] cnt_q, cnt_d;
  logic [COUNT_BITS-1:0]   rem_q, rem_d;
  logic [SUM_BITS-1:0]     quo_q, quo_d;
  logic [COUNT_BITS-1:0]   den_q, den_d;
  logic                    neg_q, neg_d;

  logic                    dvd_neg;
  logic [SUM_BITS-1:0]     dvd_mag;
  logic [COUNT_BITS:0]     shifted;
  logic [COUNT_BITS:0]     trial;
  logic                    fits;
  logic [SAMPLE_BITS-1:0]  qmag;

  assign dvd_neg = req_i.dividend[SUM_BITS-1];
  assign dvd_mag = dvd_neg ? (SUM_BITS'(0) - req_i.dividend) : req_i.dividend;

  // shift next dividend bit into the partial remainder
  assign shifted = {rem_q, quo_q[SUM_BITS-1]};
  assign fits    = shifted >= {1'b0, den_q};
  assign trial   = shifted - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_BITS'(SUM_BITS - 1);
      rem_d  = '0;
      quo_d  = dvd_mag;
      den_d  = req_i.divisor;
      neg_d  = dvd_neg;
    end else if (busy_q) begin
      rem_d = fits ? trial[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
      quo_d = {quo_q[SUM_BITS-2:0], fits};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  // the mean of in-range samples always fits the sample width
  assign qmag           = quo_q[SAMPLE_BITS-1:0];
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = neg_q ? (SAMPLE_BITS'(0) - qmag) : qmag;

endmodule

### rtl/imu_stillness_detector.sv
// ----------------------------------------------------------------------------
// imu_stillness_detector: zero-motion detection over a running imu window
// gyro and accel deviation tests, per-axis window sums and running means
// ----------------------------------------------------------------------------
// flow: a still sample is tested axis by axis, accumulated axis by axis,
//   divided once per axis for the six means, then output
// a moving sample or a full window skips the divisions
// one sample at a time: the next input beat is taken once the result of the
//   last one is loaded, later while the old result beat is stalled
// reset: window empty, sums and means zero, registers at their defaults
module imu_stillness_detector (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [isd_pkg::REG_IDX_BITS-1:0]     cfg_idx_i,
  input  logic [isd_pkg::REG_BITS-1:0]         cfg_wdata_i,
  // sample channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [isd_pkg::SAMPLE_BITS-1:0] acc_x_i,
  input  logic signed [isd_pkg::SAMPLE_BITS-1:0] acc_y_i,
  input  logic signed [isd_pkg::SAMPLE_BITS-1:0] acc_z_i,
  input  logic signed [isd_pkg::SAMPLE_BITS-1:0] gyr_x_i,
  input  logic signed [isd_pkg::SAMPLE_BITS-1:0] gyr_y_i,
  input  logic signed [isd_pkg::SAMPLE_BITS-1:0] gyr_z_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 still_ready_o,
  output logic                                 moving_o,
  output logic [isd_pkg::COUNT_BITS-1:0]       window_count_o,
  output logic signed [isd_pkg::SAMPLE_BITS-1:0] acc_mean_x_o,
  output logic signed [isd_pkg::SAMPLE_BITS-1:0] acc_mean_y_o,
  output logic signed [isd_pkg::SAMPLE_BITS-1:0] acc_mean_z_o,
  output logic signed [isd_pkg::SAMPLE_BITS-1:0] gyr_mean_x_o,
  output logic signed [isd_pkg::SAMPLE_BITS-1:0] gyr_mean_y_o,
  output logic signed [isd_pkg::SAMPLE_BITS-1:0] gyr_mean_z_o
);
  import isd_pkg::*;

  // sequencer states
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_CHECK    = 3'd1;
  localparam logic [2:0] ST_ACCUM    = 3'd2;
  localparam logic [2:0] ST_DIV_GO   = 3'd3;
  localparam logic [2:0] ST_DIV_WAIT = 3'd4;
  localparam logic [2:0] ST_OUT      = 3'd5;

  localparam logic [AXIS_BITS-1:0] LAST_AXIS = AXIS_BITS'(NUM_AXES - 1);

  // configuration registers
  logic [REG_BITS-1:0]    gyro_thr_q, accel_thr_q, min_samp_q;

  // control
  logic [2:0]             state_q, state_d;
  logic [AXIS_BITS-1:0]   idx_q, idx_d;
  logic                   moving_q, moving_d;
  logic [COUNT_BITS-1:0]  count_q, count_d;
  logic                   out_valid_q, out_valid_d;

  // window state: axes 0..2 accel, 3..5 gyro
  logic [SUM_BITS-1:0]    sums_q [NUM_AXES];
  logic [SAMPLE_BITS-1:0] mean_q [NUM_AXES];
  logic [SAMPLE_BITS-1:0] samp_q [NUM_AXES];

  // result register
  logic                   out_still_q, out_moving_q;
  logic [COUNT_BITS-1:0]  out_count_q;
  logic [SAMPLE_BITS-1:0] out_mean_q [NUM_AXES];

  div_req_t               div_req;
  div_rsp_t               div_rsp;

  logic                   is_acc;
  logic [SAMPLE_BITS-1:0] cur_samp, cur_mean;
  logic [SAMPLE_BITS:0]   diff, diff_mag;
  logic [REG_BITS-1:0]    cur_thr;
  logic                   over_thr, test_en;
  logic [SUM_BITS-1:0]    samp_ext;
  logic                   count_full;
  logic                   out_load;

  // ---------------------------------------------------------------------------
  // configuration writes, taken whenever enabled
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gyro_thr_q  <= GYRO_THR_RST;
      accel_thr_q <= ACCEL_THR_RST;
      min_samp_q  <= MIN_SAMP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GYRO_THR:  gyro_thr_q  <= cfg_wdata_i;
        REG_ACCEL_THR: accel_thr_q <= cfg_wdata_i;
        REG_MIN_SAMP:  min_samp_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // shared threshold test, one axis per cycle
  // gyro: |g| > gyro threshold
  // accel: |a - mean| > accel threshold, only with a nonempty window
  // ---------------------------------------------------------------------------
  assign is_acc   = idx_q < AXIS_BITS'(ACC_AXES);
  assign cur_samp = samp_q[idx_q];
  assign cur_mean = is_acc ? mean_q[idx_q] : '0;
  assign diff     = {cur_samp[SAMPLE_BITS-1], cur_samp} - {cur_mean[SAMPLE_BITS-1], cur_mean};
  assign diff_mag = diff[SAMPLE_BITS] ? ((SAMPLE_BITS + 1)'(0) - diff) : diff;
  assign cur_thr  = is_acc ? accel_thr_q : gyro_thr_q;
  assign over_thr = {{REG_BITS{1'b0}}, diff_mag} > {{(SAMPLE_BITS + 1){1'b0}}, cur_thr};
  assign test_en  = !is_acc || (count_q != '0);

  // sample sign-extended to the sum width for accumulation
  assign samp_ext   = {{(SUM_BITS - SAMPLE_BITS){cur_samp[SAMPLE_BITS-1]}}, cur_samp};
  assign count_full = count_q == '1;

  // the result register takes a new beat once the old one has gone
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  // divider request: current axis sum over the updated count
  assign div_req.start    = state_q == ST_DIV_GO;
  assign div_req.dividend = sums_q[idx_q];
  assign div_req.divisor  = count_q;

  isd_serial_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    moving_d    = moving_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d  = ST_CHECK;
          idx_d    = '0;
          moving_d = 1'b0;
        end
      end
      ST_CHECK: begin
        moving_d = moving_q | (over_thr & test_en);
        if (idx_q == LAST_AXIS) begin
          idx_d   = '0;
          state_d = ST_ACCUM;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_ACCUM: begin
        if (moving_q) begin
          // movement empties the window
          count_d = '0;
          state_d = ST_OUT;
        end else if (count_full) begin
          // full window: sums and means stay as they are
          state_d = ST_OUT;
        end else if (idx_q == LAST_AXIS) begin
          count_d = count_q + 1'b1;
          idx_d   = '0;
          state_d = ST_DIV_GO;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_DIV_GO: begin
        state_d = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          if (idx_q == LAST_AXIS) begin
            idx_d   = '0;
            state_d = ST_OUT;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_DIV_GO;
          end
        end
      end
      ST_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      moving_q    <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      moving_q    <= moving_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // window sums and means
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        sums_q[i] <= '0;
        mean_q[i] <= '0;
      end
    end else begin
      if (state_q == ST_ACCUM) begin
        if (moving_q) begin
          for (int i = 0; i < NUM_AXES; i++) begin
            sums_q[i] <= '0;
          end
        end else if (!count_full) begin
          sums_q[idx_q] <= sums_q[idx_q] + samp_ext;
        end
      end
      if (state_q == ST_DIV_WAIT && div_rsp.done) begin
        mean_q[idx_q] <= div_rsp.quotient;
      end
    end
  end

  // sample capture on the input beat
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      samp_q[0] <= acc_x_i;
      samp_q[1] <= acc_y_i;
      samp_q[2] <= acc_z_i;
      samp_q[3] <= gyr_x_i;
      samp_q[4] <= gyr_y_i;
      samp_q[5] <= gyr_z_i;
    end
  end

  // result register, means read as zero on an empty window
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_still_q  <= !moving_q &&
                      ({{REG_BITS{1'b0}}, count_q} >= {{COUNT_BITS{1'b0}}, min_samp_q});
      out_moving_q <= moving_q;
      out_count_q  <= count_q;
      for (int i = 0; i < NUM_AXES; i++) begin
        out_mean_q[i] <= (count_q == '0) ? '0 : mean_q[i];
      end
    end
  end

  assign in_ready_o     = state_q == ST_IDLE;
  assign out_valid_o    = out_valid_q;
  assign still_ready_o  = out_still_q;
  assign moving_o       = out_moving_q;
  assign window_count_o = out_count_q;
  assign acc_mean_x_o   = out_mean_q[0];
  assign acc_mean_y_o   = out_mean_q[1];
  assign acc_mean_z_o   = out_mean_q[2];
  assign gyr_mean_x_o   = out_mean_q[3];
  assign gyr_mean_y_o   = out_mean_q[4];
  assign gyr_mean_z_o   = out_mean_q[5];

`ifndef SYNTHESIS
  // the divider never runs on an empty window
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV_GO |-> count_q != '0)
    else $error("division started with zero count");

  // a divider result only arrives while the sequencer waits for it
  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == ST_DIV_WAIT)
    else $error("divider done outside wait state");

  // a moving beat reports an empty, not ready window
  a_moving_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && moving_o |-> window_count_o == '0 && !still_ready_o)
    else $error("moving beat with nonempty window");

  // an empty window reports zero means
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && window_count_o == '0 |->
      acc_mean_x_o == '0 && acc_mean_y_o == '0 && acc_mean_z_o == '0 &&
      gyr_mean_x_o == '0 && gyr_mean_y_o == '0 && gyr_mean_z_o == '0)
    else $error("nonzero mean on empty window");
`endif

endmodule
